### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent property wrappers; they compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CHS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property violated");
// antecedent implies consequent in the next cycle
`define CHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property violated");
`else
`define CHS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/chs_pkg.sv
// ---------------------------------------------------------------------------
// chs_pkg
// Shared types, request codes and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package chs_pkg;

    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_CAL     = 2'd1;
    localparam logic [1:0] REQ_HEADING = 2'd2;

    localparam logic [15:0] DECL_RESET = 16'd935;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    // vector datapath: 17-bit input grows by the CORDIC gain and sqrt(2)
    localparam int VEC_W = 20;

    typedef struct packed {
        logic                    heading;
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [31:0]             z;
    } vec_t;

    // atan(2^-i), 2^32 units per turn, rounded to nearest
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/compass_heading_sector_unit.sv
// ---------------------------------------------------------------------------
// compass_heading_sector_unit
// Hard-iron calibrated compass heading and twelve-sector ring position.
// ---------------------------------------------------------------------------
// Input stream: s_axis_tdata carries x_sample and y_sample, s_axis_tuser the
// request type (start calibration, calibration sample, heading sample).
// Calibration samples update the axis min/max and hard-iron offsets on the
// edge that accepts them, so a heading sample right behind sees them.
// Heading samples pass through a CORDIC pipeline of CORDIC_STEPS stages, one
// iteration per stage, then a final stage adds the declination and forms the
// sector. Every input yields exactly one result transaction.
// Throughput: one transaction per cycle while the output is not stalled, set
// by the per-stage pipeline registers.
// Each stage advances when the stage after it is empty or moving, so input
// is still taken while a result waits in the output register; a stalled
// receiver fills the pipeline and then drops s_axis_tready.
// Reset clears all pipeline valid bits, the min/max and offset registers,
// and loads the declination with 935 (about 5 degrees 8 minutes).
// cfg_we writes cfg_wdata into the declination register; write it idle only.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module compass_heading_sector_unit #(
    parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // declination
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] x_sample, [31:16] y_sample
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [3:0] sector, [19:4] heading_angle, rest 0
    output logic        m_axis_tuser   // [0] heading_valid
);

    localparam int VW = chs_pkg::VEC_W;

    logic [15:0]        decl_reg;
    logic signed [15:0] x_max_reg, x_min_reg, y_max_reg, y_min_reg;
    logic signed [15:0] x_max_next, x_min_next, y_max_next, y_min_next;
    logic signed [15:0] off_x_reg, off_y_reg, off_x_next, off_y_next;
    logic signed [16:0] sum_x, sum_y, half_x, half_y;

    logic signed [15:0] x_in, y_in;
    logic signed [16:0] dx, dy;
    logic               s_fire;

    chs_pkg::vec_t      pipe_reg [0:CORDIC_STEPS];
    chs_pkg::vec_t      stage_out [0:CORDIC_STEPS-1];
    chs_pkg::vec_t      head_vec;
    logic [CORDIC_STEPS:0] vld_reg;
    logic [CORDIC_STEPS:0] load;
    logic               out_free;

    logic [31:0]        z_rnd;
    logic [15:0]        angle;
    logic [15:0]        heading;
    logic [19:0]        h12;
    logic [3:0]         sector_reg;
    logic [15:0]        heading_reg;
    logic               hv_reg;

    assign x_in   = s_axis_tdata[15:0];
    assign y_in   = s_axis_tdata[31:16];
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // calibration: extremes, then offsets truncated toward zero
    always_comb
    begin
        x_max_next = x_max_reg;
        x_min_next = x_min_reg;
        y_max_next = y_max_reg;
        y_min_next = y_min_reg;
        case (s_axis_tuser)
            chs_pkg::REQ_START:
            begin
                x_max_next = x_in;
                x_min_next = x_in;
                y_max_next = y_in;
                y_min_next = y_in;
            end
            chs_pkg::REQ_CAL:
            begin
                if (x_in > x_max_reg) x_max_next = x_in;
                if (x_in < x_min_reg) x_min_next = x_in;
                if (y_in > y_max_reg) y_max_next = y_in;
                if (y_in < y_min_reg) y_min_next = y_in;
            end
            default:
            begin
            end
        endcase
        sum_x      = 17'(x_max_next) + 17'(x_min_next);
        sum_y      = 17'(y_max_next) + 17'(y_min_next);
        half_x     = (sum_x + {16'd0, sum_x[16]}) >>> 1;
        half_y     = (sum_y + {16'd0, sum_y[16]}) >>> 1;
        off_x_next = half_x[15:0];
        off_y_next = half_y[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg  <= chs_pkg::DECL_RESET;
            x_max_reg <= '0;
            x_min_reg <= '0;
            y_max_reg <= '0;
            y_min_reg <= '0;
            off_x_reg <= '0;
            off_y_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                decl_reg <= cfg_wdata;
            if (s_fire)
            begin
                x_max_reg <= x_max_next;
                x_min_reg <= x_min_next;
                y_max_reg <= y_max_next;
                y_min_reg <= y_min_next;
                off_x_reg <= off_x_next;
                off_y_reg <= off_y_next;
            end
        end
    end

    // offset removal, exact at 17 bits
    assign dx = 17'(x_in) - 17'(off_x_reg);
    assign dy = 17'(y_in) - 17'(off_y_reg);

    always_comb
    begin
        head_vec.heading = (s_axis_tuser == chs_pkg::REQ_HEADING);
        head_vec.zero    = (dx == 17'sd0) && (dy == 17'sd0);
        head_vec.x       = VW'(dx);
        head_vec.y       = VW'(dy);
        head_vec.z       = 32'h00000000;
    end

    // stage flow control: load when empty or when the content moves on
    assign out_free = !m_axis_tvalid || m_axis_tready;

    always_comb
    begin
        load[CORDIC_STEPS] = !vld_reg[CORDIC_STEPS] || out_free;
        for (int i = CORDIC_STEPS - 1; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign s_axis_tready = load[0];

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_iter
            chs_cordic_stage #(
                .STEP (g)
            ) u_stage (
                .vin  (pipe_reg[g]),
                .vout (stage_out[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (load[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                if (load[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
            if (out_free)
                m_axis_tvalid <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            pipe_reg[0] <= head_vec;
        for (int i = 1; i <= CORDIC_STEPS; i++)
        begin
            if (load[i] && vld_reg[i-1])
                pipe_reg[i] <= stage_out[i-1];
        end
        if (out_free && vld_reg[CORDIC_STEPS])
        begin
            sector_reg  <= pipe_reg[CORDIC_STEPS].heading ? h12[19:16] : 4'd0;
            heading_reg <= pipe_reg[CORDIC_STEPS].heading ? heading : 16'd0;
            hv_reg      <= pipe_reg[CORDIC_STEPS].heading;
        end
    end

    // round to 16 bits, add declination, scale by twelve sectors
    assign z_rnd   = pipe_reg[CORDIC_STEPS].z + 32'h00008000;
    assign angle   = pipe_reg[CORDIC_STEPS].zero ? 16'd0 : z_rnd[31:16];
    assign heading = angle + decl_reg;
    assign h12     = {1'b0, heading, 3'b000} + {2'b00, heading, 2'b00};

    assign m_axis_tdata = {4'd0, heading_reg, sector_reg};
    assign m_axis_tuser = hv_reg;

    `CHS_ASSERT_SAME(a_min_le_max, clk, rst_n, 1'b1, (x_min_reg <= x_max_reg) && (y_min_reg <= y_max_reg))
    `CHS_ASSERT_NEXT(a_start_seeds, clk, rst_n, s_fire && (s_axis_tuser == chs_pkg::REQ_START), (x_min_reg == x_max_reg) && (y_min_reg == y_max_reg))
    `CHS_ASSERT_SAME(a_sector_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd11)
    `CHS_ASSERT_SAME(a_cal_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 24'd0)
    `CHS_ASSERT_SAME(a_stall_full, clk, rst_n, !s_axis_tready, vld_reg[0] && !out_free)

endmodule

### hw/rtl/chs_cordic_stage.sv
// ---------------------------------------------------------------------------
// chs_cordic_stage
// One vectoring-mode CORDIC iteration; the first one also folds the left
// half plane onto the right half plane.
// ---------------------------------------------------------------------------
module chs_cordic_stage #(
    parameter int STEP = 0
) (
    input  chs_pkg::vec_t vin,
    output chs_pkg::vec_t vout
);

    chs_pkg::vec_t                    pre;
    logic signed [chs_pkg::VEC_W-1:0] xs;
    logic signed [chs_pkg::VEC_W-1:0] ys;
    logic [31:0]                      ang;

    assign ang = chs_pkg::atan_turn(5'(STEP));

    always_comb
    begin
        pre = vin;
        if (STEP == 0 && vin.x < 0)
        begin
            pre.x = -vin.x;
            pre.y = -vin.y;
            pre.z = 32'h80000000;
        end
        else if (STEP == 0)
        begin
            pre.z = 32'h00000000;
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign xs = pre.x >>> STEP;
    assign ys = pre.y >>> STEP;

    always_comb
    begin
        vout = pre;
        if (pre.y >= 0)
        begin
            vout.x = pre.x + ys;
            vout.y = pre.y - xs;
            vout.z = pre.z + ang;
        end
        else
        begin
            vout.x = pre.x - ys;
            vout.y = pre.y + xs;
            vout.z = pre.z - ang;
        end
    end

endmodule

### tb/compass_heading_sector_checker.sv
// ---------------------------------------------------------------------------
// compass_heading_sector_checker
// Watches both streams of the heading unit, keeps its own copy of the
// calibration extremes, offsets and declination, predicts each result with a
// bit-exact vectoring CORDIC and compares every output transaction in order.
// ---------------------------------------------------------------------------
module compass_heading_sector_checker #(
    parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] x_sample, [31:16] y_sample
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,  // [3:0] sector, [19:4] heading_angle
    input  logic        m_axis_tuser,  // [0] heading_valid
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import chs_pkg::*;

    // arctangent of 2^-i, 2^32 per turn
    localparam logic [31:0] ARC_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [3:0]  sector;
        logic [15:0] angle;
        logic        valid;
    } bearing_t;

    bearing_t           bearing_due[$];
    logic [15:0]        decl;
    logic signed [15:0] x_hi, x_lo, y_hi, y_lo, off_x, off_y;

    function automatic logic [15:0] vector_angle(longint vx, longint vy);
        logic [31:0] acc;
        logic [31:0] rounded;
        longint      sx, sy;
        int          i;
        if (vx == 0 && vy == 0)
            return 16'd0;
        acc = 32'd0;
        // fold the left half plane onto the right one
        if (vx < 0)
        begin
            vx  = -vx;
            vy  = -vy;
            acc = 32'h8000_0000;
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0)
            begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + ARC_TURNS[i];
            end
            else
            begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - ARC_TURNS[i];
            end
        end
        rounded = acc + 32'h0000_8000;
        return rounded[31:16];
    endfunction

    // hard-iron offset, truncated toward zero
    function automatic logic signed [15:0] midpoint(logic signed [15:0] hi,
                                                    logic signed [15:0] lo);
        int sum;
        sum = int'(hi) + int'(lo);
        return 16'(sum / 2);
    endfunction

    function automatic bearing_t compass_step(logic [1:0] req, logic signed [15:0] xs,
                                              logic signed [15:0] ys);
        bearing_t    r;
        logic [15:0] ang;
        logic [31:0] scaled;
        r = '0;
        case (req)
            REQ_START:
            begin
                x_hi  = xs;
                x_lo  = xs;
                y_hi  = ys;
                y_lo  = ys;
                off_x = midpoint(x_hi, x_lo);
                off_y = midpoint(y_hi, y_lo);
            end
            REQ_CAL:
            begin
                if (xs > x_hi) x_hi = xs;
                if (xs < x_lo) x_lo = xs;
                if (ys > y_hi) y_hi = ys;
                if (ys < y_lo) y_lo = ys;
                off_x = midpoint(x_hi, x_lo);
                off_y = midpoint(y_hi, y_lo);
            end
            REQ_HEADING:
            begin
                ang = vector_angle(longint'(xs) - longint'(off_x),
                                   longint'(ys) - longint'(off_y)) + decl;
                scaled   = {16'd0, ang} * 32'd12;
                r.sector = scaled[19:16];
                r.angle  = ang;
                r.valid  = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        bearing_t due;
        if (!rst_n)
        begin
            decl  = DECL_RESET;
            x_hi  = '0;
            x_lo  = '0;
            y_hi  = '0;
            y_lo  = '0;
            off_x = '0;
            off_y = '0;
            bearing_due.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                decl = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (bearing_due.size() == 0)
                begin
                    $error("result transaction with none expected: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    due = bearing_due.pop_front();
                    if (m_axis_tdata[3:0] !== due.sector)
                    begin
                        $error("sector: expected %0d, actual %0d",
                               due.sector, m_axis_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[19:4] !== due.angle)
                    begin
                        $error("heading_angle: expected %0d, actual %0d",
                               due.angle, m_axis_tdata[19:4]);
                        fail_count++;
                    end
                    if (m_axis_tuser !== due.valid)
                    begin
                        $error("heading_valid: expected %0d, actual %0d",
                               due.valid, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                bearing_due.push_back(compass_step(s_axis_tuser, s_axis_tdata[15:0],
                                                   s_axis_tdata[31:16]));
            pending = bearing_due.size();
        end
    end

endmodule

### tb/tb_compass_heading_sector_unit.sv
// ---------------------------------------------------------------------------
// tb_compass_heading_sector_unit
// Drives calibration runs, heading samples and stray request codes into the
// heading unit under random source and sink gaps, a long sink hold-off and
// several declination settings; the checker beside the unit predicts and
// compares, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_compass_heading_sector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import chs_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         PIPE_DEPTH  = CORDIC_STEPS_DEF + 1;
    localparam int         STALL_LIMIT = 5000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // [15:0] x_sample, [31:16] y_sample
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [3:0] sector, [19:4] heading_angle
    logic        m_axis_tuser;        // [0] heading_valid

    int   src_idle_pct = 23;
    int   snk_idle_pct = 51;
    logic hold_go      = 1'b0;
    int   hold_left    = 120;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;

    always #10 clk = ~clk;

    compass_heading_sector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    compass_heading_sector_checker heading_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // sink: hold off once for a long stretch so the pipeline backs up
    always @(posedge clk)
    begin
        if (hold_go && hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_compass_heading_sector_unit NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_sample(logic [1:0] req, logic signed [15:0] xs,
                               logic signed [15:0] ys);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ys, xs};
        s_axis_tuser  <= req;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    task automatic write_declination(logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [15:0] axis_value();
        int t;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       t = -32768;
                    1:       t = 32767;
                    2:       t = 0;
                    3:       t = -1;
                    default: t = 1;
                endcase
            end
            1, 2:    t = $urandom_range(0, 127) - 64;
            default: t = $urandom;
        endcase
        return 16'(t);
    endfunction

    // mostly calibration runs followed by heading bursts, some stray requests
    task automatic run_traffic(int n);
        int sent, k;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_sample(REQ_START, axis_value(), axis_value());
                k = $urandom_range(1, 24);
                repeat (k) send_sample(REQ_CAL, axis_value(), axis_value());
                sent += k + 1;
                k = $urandom_range(1, 30);
                repeat (k) send_sample(REQ_HEADING, axis_value(), axis_value());
                sent += k;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_sample(2'($urandom_range(0, 3)), axis_value(), axis_value());
                sent += k;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset declination; calibrate without a start first
        send_sample(REQ_CAL, 100, -50);
        send_sample(REQ_HEADING, 50, -25);
        send_sample(REQ_START, 0, 0);
        send_sample(REQ_HEADING, 0, 0);
        send_sample(REQ_HEADING, 32767, 0);
        send_sample(REQ_HEADING, -32768, 0);
        send_sample(REQ_HEADING, 0, 32767);
        send_sample(REQ_HEADING, 0, -32768);
        send_sample(REQ_HEADING, 32767, 32767);
        send_sample(REQ_HEADING, -32768, -32768);
        send_sample(REQ_HEADING, -32768, 32767);
        send_sample(REQ_HEADING, 32767, -32768);
        send_sample(REQ_HEADING, -1, 0);
        send_sample(REQ_HEADING, -1, -1);
        send_sample(REQ_UNUSED, 1234, -4321);
        // offsets of -1/2 truncate to zero
        send_sample(REQ_START, -32768, 32767);
        send_sample(REQ_CAL, 32767, -32768);
        send_sample(REQ_HEADING, -3, 5);
        // offsets at the extremes stretch the vector to 17 bits
        send_sample(REQ_START, -32768, -32768);
        send_sample(REQ_HEADING, 32767, 32767);
        send_sample(REQ_CAL, -32768, -32768);
        send_sample(REQ_HEADING, -32768, 32767);
        send_sample(REQ_START, 32767, 32767);
        send_sample(REQ_HEADING, -32768, -32768);
        send_sample(REQ_HEADING, -32768, 0);

        drain_pipeline();
        write_declination(16'h0000);
        run_traffic(550);

        drain_pipeline();
        src_idle_pct = 51;
        snk_idle_pct <= 23;
        write_declination(16'hFFFF);
        run_traffic(550);

        drain_pipeline();
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        write_declination(16'($urandom));
        hold_go <= 1'b1;
        run_traffic(500);

        drain_pipeline();
        if (fail_count == 0)
            $display("tb_compass_heading_sector_unit OK");
        else
            $display("tb_compass_heading_sector_unit NOT OK");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/chs_pkg.sv
hw/rtl/chs_cordic_stage.sv
hw/rtl/compass_heading_sector_unit.sv
tb/compass_heading_sector_checker.sv
tb/tb_compass_heading_sector_unit.sv
